// ----- src/v3a_pkg.sv -----
package v3a_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CMD_W  = 3;

    localparam logic [CMD_W-1:0] CMD_SCALE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADDS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SUBS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ADDV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SUBV  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_MAG   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NORM  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] b_x;
        logic signed [WORD_W-1:0] b_y;
        logic signed [WORD_W-1:0] b_z;
        logic signed [WORD_W-1:0] scalar;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] r_x;
        logic signed [WORD_W-1:0] r_y;
        logic signed [WORD_W-1:0] r_z;
        logic [WORD_W-1:0]        magnitude;
        logic                     div_zero;
        logic                     saturated;
    } t_rsp;

endpackage

// ----- src/v3a_if.sv -----
interface v3a_req_if;
    logic          valid;
    logic          ready;
    v3a_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface v3a_rsp_if;
    logic          valid;
    logic          ready;
    v3a_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/v3a_sqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
// Sideband data of width SIDE_W rides along. Advances when i_en is high.
module v3a_sqrt #(
    parameter int unsigned IN_W   = 66,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic [IN_W/2-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int unsigned RW = IN_W / 2;

    logic [IN_W-1:0]   r_rem  [RW+1];
    logic [IN_W-1:0]   r_n    [RW+1];
    logic [RW-1:0]     r_root [RW+1];
    logic [SIDE_W-1:0] r_side [RW+1];

    always_comb begin
        r_rem[0]  = '0;
        r_n[0]    = i_rad;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [IN_W-1:0] n_rem;
        logic [IN_W-1:0] n_trial;
        always_comb begin
            n_rem   = {r_rem[g][IN_W-3:0], r_n[g][IN_W-1 -: 2]};
            n_trial = {r_root[g], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g+1]    <= {r_n[g][IN_W-3:0], 2'b00};
                r_side[g+1] <= r_side[g];
                if (n_rem >= n_trial) begin
                    r_rem[g+1]  <= n_rem - n_trial;
                    r_root[g+1] <= {r_root[g][RW-2:0], 1'b1};
                end else begin
                    r_rem[g+1]  <= n_rem;
                    r_root[g+1] <= {r_root[g][RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[RW];
    assign o_side = r_side[RW];
endmodule

// ----- src/v3a_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3a_div #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 32,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    logic [NUM_W-1:0]  r_q   [NUM_W+1];
    logic [DEN_W:0]    r_rem [NUM_W+1];
    logic [DEN_W-1:0]  r_den [NUM_W+1];
    logic [SIDE_W-1:0] r_side[NUM_W+1];

    always_comb begin
        r_q[0]    = i_num;
        r_rem[0]  = '0;
        r_den[0]  = i_den;
        r_side[0] = i_side;
    end

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [DEN_W:0] n_rem;
        always_comb n_rem = {r_rem[g][DEN_W-1:0], r_q[g][NUM_W-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1]  <= r_den[g];
                r_side[g+1] <= r_side[g];
                if (n_rem >= {1'b0, r_den[g]}) begin
                    r_rem[g+1] <= n_rem - {1'b0, r_den[g]};
                    r_q[g+1]   <= {r_q[g][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= n_rem;
                    r_q[g+1]   <= {r_q[g][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo  = r_q[NUM_W];
    assign o_side = r_side[NUM_W];
endmodule

// ----- src/vec3_arith_unit.sv -----
// Channel  | Dir | Payload
// i_req    | in  | cmd, a_x..a_z, b_x..b_z, scalar
// o_rsp    | out | r_x, r_y, r_z, magnitude, div_zero, saturated
//
// One request per cycle while the output is not stalled. Pipeline stages:
// 2 stages for squares and sum, 33 for the square root, 32 + FRAC_BITS for
// the three parallel dividers, 2 for product, clamp and output. The whole pipe
// advances together, so a stalled output holds every stage and nothing is
// lost. Reset clears the valid bits only.
module vec3_arith_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    v3a_req_if.sink   i_req,
    v3a_rsp_if.source o_rsp
);
    localparam int unsigned W     = v3a_pkg::WORD_W;
    localparam int unsigned SQ_W  = 66;
    localparam int unsigned RT_W  = SQ_W / 2;
    localparam int unsigned NUM_W = W + FRAC_BITS;
    localparam int unsigned SIDE_W = $bits(v3a_pkg::t_req);
    localparam int unsigned LAT   = 2 + RT_W + NUM_W + 2;

    logic          w_en;
    logic [LAT-1:0] r_vld;

    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // Stage 1: squares of |a|.
    v3a_pkg::t_req r_s1;
    logic [2*W-1:0] r_sq [3];
    logic [W-1:0] w_abs [3];
    always_comb begin
        w_abs[0] = i_req.payload.a_x[W-1] ? W'(-i_req.payload.a_x) : i_req.payload.a_x;
        w_abs[1] = i_req.payload.a_y[W-1] ? W'(-i_req.payload.a_y) : i_req.payload.a_y;
        w_abs[2] = i_req.payload.a_z[W-1] ? W'(-i_req.payload.a_z) : i_req.payload.a_z;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= i_req.payload;
            for (int k = 0; k < 3; k++) r_sq[k] <= w_abs[k] * w_abs[k];
        end
    end

    // Stage 2: sum of squares.
    v3a_pkg::t_req r_s2;
    logic [SQ_W-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2  <= r_s1;
            r_sum <= SQ_W'(r_sq[0]) + SQ_W'(r_sq[1]) + SQ_W'(r_sq[2]);
        end
    end

    logic [RT_W-1:0] w_root;
    v3a_pkg::t_req   w_s3;
    v3a_sqrt #(.IN_W(SQ_W), .SIDE_W(SIDE_W)) u_sqrt (
        .i_clk (i_clk), .i_en (w_en), .i_rad (r_sum),
        .i_side (r_s2), .o_root (w_root), .o_side (w_s3)
    );

    // Divisor choice: |s| for divide, magnitude for normalize.
    logic [W-1:0] w_mag;
    logic [W-1:0] w_sabs;
    logic [W-1:0] w_den;
    logic         w_dz;
    logic         w_dneg;
    logic [W-1:0] w_num [3];
    logic [W-1:0] w_a [3];
    assign w_mag  = w_root[W-1:0];
    assign w_sabs = w_s3.scalar[W-1] ? W'(-w_s3.scalar) : w_s3.scalar;
    always_comb begin
        w_a[0] = w_s3.a_x; w_a[1] = w_s3.a_y; w_a[2] = w_s3.a_z;
        for (int k = 0; k < 3; k++) w_num[k] = w_a[k][W-1] ? W'(-w_a[k]) : w_a[k];
        if (w_s3.cmd == v3a_pkg::CMD_NORM) begin
            w_den  = w_root[W-1:0];
            w_dneg = 1'b0;
        end else begin
            w_den  = w_sabs;
            w_dneg = w_s3.scalar[W-1];
        end
        w_dz = (w_den == '0);
    end

    // Side word through the dividers: request, magnitude, divisor sign, zero flag.
    localparam int unsigned DS_W = $bits(v3a_pkg::t_req) + W + 2;
    logic [NUM_W-1:0] w_q [3];
    logic [DS_W-1:0]  w_dside [3];
    for (genvar g = 0; g < 3; g++) begin : g_div
        v3a_div #(.NUM_W(NUM_W), .DEN_W(W), .SIDE_W(DS_W)) u_div (
            .i_clk (i_clk), .i_en (w_en),
            .i_num ({w_num[g], FRAC_BITS'(0)}),
            .i_den (w_dz ? W'(1) : w_den),
            .i_side ({w_s3, w_mag, w_dneg, w_dz}),
            .o_quo (w_q[g]), .o_side (w_dside[g])
        );
    end

    v3a_pkg::t_req w_s4;
    logic [W-1:0]  w_mag4;
    logic          w_dneg4;
    logic          w_dz4;
    assign {w_s4, w_mag4, w_dneg4, w_dz4} = w_dside[0];

    // Divider output: sums and differences and the div-zero flag are formed here from the carried operands.
    logic signed [W+1:0] w_r [3];
    logic [2*W-1:0]      w_p [3];
    logic                w_dzf;
    logic signed [W-1:0] w_b [3];
    logic signed [W-1:0] w_a4 [3];
    always_comb begin
        w_a4[0] = w_s4.a_x; w_a4[1] = w_s4.a_y; w_a4[2] = w_s4.a_z;
        w_b[0] = w_s4.b_x; w_b[1] = w_s4.b_y; w_b[2] = w_s4.b_z;
        w_dzf = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_p[k] = '0;
            w_r[k] = '0;
        end
        case (w_s4.cmd)
            v3a_pkg::CMD_ADDS: for (int k = 0; k < 3; k++)
                w_r[k] = (W+2)'(w_a4[k]) + (W+2)'(w_s4.scalar);
            v3a_pkg::CMD_SUBS: for (int k = 0; k < 3; k++)
                w_r[k] = (W+2)'(w_a4[k]) - (W+2)'(w_s4.scalar);
            v3a_pkg::CMD_ADDV: for (int k = 0; k < 3; k++)
                w_r[k] = (W+2)'(w_a4[k]) + (W+2)'(w_b[k]);
            v3a_pkg::CMD_SUBV: for (int k = 0; k < 3; k++)
                w_r[k] = (W+2)'(w_a4[k]) - (W+2)'(w_b[k]);
            default: ;
        endcase
        if (w_s4.cmd == v3a_pkg::CMD_DIV || w_s4.cmd == v3a_pkg::CMD_NORM) w_dzf = w_dz4;
    end

    // Product stage registers, then clamp stage.
    logic [2*W-1:0]     r_prod [3];
    logic [NUM_W-1:0]   r_quo [3];
    logic signed [W+1:0] r_lin [3];
    logic [2:0]         r_neg;
    v3a_pkg::t_req      r_s5;
    logic [W-1:0]       r_mag5;
    logic               r_dz5;
    logic               r_dneg5;
    logic [W-1:0]       w_sa;
    assign w_sa = w_s4.scalar[W-1] ? W'(-w_s4.scalar) : w_s4.scalar;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= (w_a4[k][W-1] ? W'(-w_a4[k]) : W'(w_a4[k])) * w_sa;
                r_quo[k]  <= w_q[k];
                r_lin[k]  <= w_r[k];
                r_neg[k]  <= w_a4[k][W-1];
            end
            r_s5    <= w_s4;
            r_mag5  <= w_mag4;
            r_dz5   <= w_dzf;
            r_dneg5 <= w_dneg4;
        end
    end

    // Signed result, clamp.
    localparam logic signed [W+FRAC_BITS+W:0] MAXV = (W+FRAC_BITS+W+1)'(32'h7FFF_FFFF);
    localparam logic signed [W+FRAC_BITS+W:0] MINV = -(W+FRAC_BITS+W+1)'(33'h0_8000_0000);
    localparam int unsigned EW = W + FRAC_BITS + W + 1;
    logic signed [EW-1:0] w_full [3];
    logic [2*W-1:0]       w_pm;
    logic                 w_ng;
    v3a_pkg::t_rsp        w_rsp;
    logic [W-1:0]         w_res [3];
    always_comb begin
        w_rsp     = '0;
        w_pm      = '0;
        w_ng      = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_full[k] = '0;
            case (r_s5.cmd)
                v3a_pkg::CMD_SCALE: begin
                    w_pm = r_prod[k] >> FRAC_BITS;
                    w_ng = r_neg[k] != r_s5.scalar[W-1];
                    w_full[k] = w_ng ? -EW'(w_pm) : EW'(w_pm);
                end
                v3a_pkg::CMD_DIV, v3a_pkg::CMD_NORM: begin
                    w_ng = r_neg[k] != r_dneg5;
                    w_full[k] = w_ng ? -EW'(r_quo[k]) : EW'(r_quo[k]);
                end
                v3a_pkg::CMD_MAG: w_full[k] = '0;
                default: w_full[k] = EW'(r_lin[k]);
            endcase
            if (r_dz5) begin
                w_res[k] = '0;
            end else if (w_full[k] > MAXV) begin
                w_res[k] = 32'h7FFF_FFFF;
                w_rsp.saturated = 1'b1;
            end else if (w_full[k] < MINV) begin
                w_res[k] = 32'h8000_0000;
                w_rsp.saturated = 1'b1;
            end else begin
                w_res[k] = w_full[k][W-1:0];
            end
        end
        w_rsp.r_x       = w_res[0];
        w_rsp.r_y       = w_res[1];
        w_rsp.r_z       = w_res[2];
        w_rsp.magnitude = r_mag5;
        w_rsp.div_zero  = r_dz5;
    end

    v3a_pkg::t_rsp r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= w_rsp;
    end

    assign o_rsp.valid   = r_vld[LAT-1];
    assign o_rsp.payload = r_out;
endmodule

// ----- src/v3a_checker.sv -----
module v3a_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_ready,
    input logic o_rsp_valid,
    input logic o_rsp_ready,
    input logic o_div_zero,
    input logic o_saturated
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid) else $error("response dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> $stable(o_div_zero) && $stable(o_saturated))
        else $error("response changed while held");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_ready |-> i_req_ready) else $error("ready lost with open output");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_div_zero && o_saturated)) else $error("both flags set");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid) else $error("valid after reset");
endmodule

bind vec3_arith_unit v3a_checker u_chk (
    .i_clk (i_clk), .i_rst_n (i_rst_n),
    .i_req_ready (i_req.ready),
    .o_rsp_valid (o_rsp.valid), .o_rsp_ready (o_rsp.ready),
    .o_div_zero (o_rsp.payload.div_zero), .o_saturated (o_rsp.payload.saturated)
);
